[design/assert_macros.svh]
// Assertion helpers shared by the RTL; every use samples on clk and is
// disabled while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[design/dos_pkg.sv]
`default_nettype none
package dos_pkg;

  // Level and arithmetic widths
  localparam int LEVEL_BITS = 11;
  localparam int SUM_W      = LEVEL_BITS + 1;
  localparam int ERR_W      = 16;
  localparam int QUO_W      = ERR_W - 1;
  localparam int GAIN_W     = 16;
  localparam int LIM_W      = 15;
  localparam int DIFF_W     = ERR_W + 1;
  localparam int PROD_W     = GAIN_W + DIFF_W;
  localparam int ACC_W      = PROD_W + 1;
  localparam int FRAC_BITS  = 15;
  localparam int PD_W       = ACC_W - FRAC_BITS;
  localparam int OUT_W      = 16;

  // Stream widths
  localparam int IN_TDATA_W  = ((2 * LEVEL_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_W = 2 * OUT_W;

  // Divider sequencing: one quotient bit per step
  localparam int DIV_STEPS = QUO_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  // Register file
  localparam int ADDR_W   = 4;
  localparam int APB_DW   = 32;
  localparam logic [1:0] REG_PROP_GAIN  = 2'd0;
  localparam logic [1:0] REG_DERIV_GAIN = 2'd1;
  localparam logic [1:0] REG_OUT_LIMIT  = 2'd2;
  localparam logic [LIM_W-1:0] LIMIT_RESET = {LIM_W{1'b1}};

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic div_step;
    logic sign;
    logic mul_p;
    logic mul_d;
    logic acc_add;
    logic finish;
  } dos_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic zero_level;
  } dos_sts_t;

endpackage
`default_nettype wire

[design/dos_regs.sv]
`default_nettype none
module dos_regs (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [dos_pkg::ADDR_W-1:0]        paddr,
  input  wire logic [dos_pkg::APB_DW-1:0]        pwdata,
  output logic      [dos_pkg::APB_DW-1:0]        prdata,
  output logic                                   pready,
  output logic signed [dos_pkg::GAIN_W-1:0]      prop_gain,
  output logic signed [dos_pkg::GAIN_W-1:0]      deriv_gain,
  output logic      [dos_pkg::LIM_W-1:0]         out_limit
);

  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel & penable & pwrite & pready;

  // Write registers on the access cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain  <= '0;
      deriv_gain <= '0;
      out_limit  <= dos_pkg::LIMIT_RESET;
    end else if (wr_en) begin
      case (reg_idx)
        dos_pkg::REG_PROP_GAIN:  prop_gain  <= pwdata[dos_pkg::GAIN_W-1:0];
        dos_pkg::REG_DERIV_GAIN: deriv_gain <= pwdata[dos_pkg::GAIN_W-1:0];
        dos_pkg::REG_OUT_LIMIT:  out_limit  <= pwdata[dos_pkg::LIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (reg_idx)
      dos_pkg::REG_PROP_GAIN:
        prdata = {{(dos_pkg::APB_DW-dos_pkg::GAIN_W){1'b0}}, prop_gain};
      dos_pkg::REG_DERIV_GAIN:
        prdata = {{(dos_pkg::APB_DW-dos_pkg::GAIN_W){1'b0}}, deriv_gain};
      dos_pkg::REG_OUT_LIMIT:
        prdata = {{(dos_pkg::APB_DW-dos_pkg::LIM_W){1'b0}}, out_limit};
      default:
        prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

[design/dos_dpath.sv]
`default_nettype none
module dos_dpath (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire dos_pkg::dos_cmd_t                 cmd,
  output dos_pkg::dos_sts_t                      sts,
  input  wire logic [dos_pkg::LEVEL_BITS-1:0]    left_level,
  input  wire logic [dos_pkg::LEVEL_BITS-1:0]    right_level,
  input  wire logic signed [dos_pkg::GAIN_W-1:0] prop_gain,
  input  wire logic signed [dos_pkg::GAIN_W-1:0] deriv_gain,
  input  wire logic [dos_pkg::LIM_W-1:0]         out_limit,
  output logic signed [dos_pkg::OUT_W-1:0]       steer_out,
  output logic signed [dos_pkg::ERR_W-1:0]       norm_error,
  output logic                                   error_held
);

  localparam int SUM_W  = dos_pkg::SUM_W;
  localparam int ERR_W  = dos_pkg::ERR_W;
  localparam int QUO_W  = dos_pkg::QUO_W;
  localparam int PROD_W = dos_pkg::PROD_W;
  localparam int ACC_W  = dos_pkg::ACC_W;
  localparam int PD_W   = dos_pkg::PD_W;

  // Operand and divider registers
  logic [SUM_W-1:0]          sum;
  logic [SUM_W-1:0]          rem;
  logic [QUO_W-1:0]          quo;
  logic                      neg;
  logic                      zero_level;
  logic signed [ERR_W-1:0]   e_new;
  logic signed [ERR_W-1:0]   held_error;
  logic signed [PROD_W-1:0]  prod;
  logic signed [ACC_W-1:0]   acc;

  logic [SUM_W:0]            rem_shift;
  logic                      rem_ge;
  logic [SUM_W-1:0]          mag;
  logic signed [ERR_W-1:0]   q_signed;
  logic signed [dos_pkg::DIFF_W-1:0] de;
  logic signed [dos_pkg::GAIN_W-1:0] mul_a;
  logic signed [dos_pkg::DIFF_W-1:0] mul_b;
  logic signed [PD_W-1:0]    pd;
  logic signed [PD_W-1:0]    lim_pos;
  logic signed [PD_W-1:0]    lim_neg;
  logic signed [PD_W-1:0]    pd_clamp;

  assign sts.zero_level = zero_level;

  // Magnitude of the difference at load time
  assign mag = (left_level >= right_level)
             ? SUM_W'(left_level - right_level)
             : SUM_W'(right_level - left_level);

  // One restoring division step
  assign rem_shift = {rem, 1'b0};
  assign rem_ge    = rem_shift >= {1'b0, sum};

  assign q_signed = neg ? -signed'({1'b0, quo}) : signed'({1'b0, quo});
  assign de       = {e_new[ERR_W-1], e_new} - {held_error[ERR_W-1], held_error};

  // Shared 16 x 17 multiplier operand select
  assign mul_a = cmd.mul_d ? deriv_gain : prop_gain;
  assign mul_b = cmd.mul_d ? de : dos_pkg::DIFF_W'(e_new);

  // Floor shift and clamp
  assign pd      = acc[ACC_W-1:dos_pkg::FRAC_BITS];
  assign lim_pos = signed'({{(PD_W-dos_pkg::LIM_W){1'b0}}, out_limit});
  assign lim_neg = -lim_pos;
  always_comb begin
    if (pd > lim_pos) begin
      pd_clamp = lim_pos;
    end else if (pd < lim_neg) begin
      pd_clamp = lim_neg;
    end else begin
      pd_clamp = pd;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sum        <= SUM_W'(left_level) + SUM_W'(right_level);
      rem        <= mag;
      neg        <= left_level < right_level;
      zero_level <= (left_level == '0) || (right_level == '0);
      quo        <= '0;
    end
    if (cmd.div_step) begin
      rem <= rem_ge ? SUM_W'(rem_shift - {1'b0, sum}) : rem_shift[SUM_W-1:0];
      quo <= {quo[QUO_W-2:0], rem_ge};
    end
    if (cmd.sign) begin
      e_new <= zero_level ? held_error : q_signed;
    end
    if (cmd.mul_p || cmd.mul_d) begin
      prod <= PROD_W'(mul_a) * PROD_W'(mul_b);
    end
    if (cmd.mul_d) begin
      acc <= ACC_W'(prod);
    end
    if (cmd.acc_add) begin
      acc <= acc + ACC_W'(prod);
    end
    if (cmd.finish) begin
      steer_out  <= pd_clamp[dos_pkg::OUT_W-1:0];
      norm_error <= e_new;
      error_held <= zero_level;
    end
  end

  // Held error is loop state
  always_ff @(posedge clk) begin
    if (rst) begin
      held_error <= '0;
    end else if (cmd.finish) begin
      held_error <= e_new;
    end
  end

endmodule
`default_nettype wire

[design/dos_ctrl.sv]
`default_nettype none
`include "assert_macros.svh"
module dos_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               s_tvalid,
  output logic                    s_tready,
  output logic                    m_tvalid,
  input  wire logic               m_tready,
  input  wire dos_pkg::dos_sts_t  sts,
  output dos_pkg::dos_cmd_t       cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_SIGN = 3'd2;
  localparam logic [2:0] S_MULP = 3'd3;
  localparam logic [2:0] S_MULD = 3'd4;
  localparam logic [2:0] S_ACC  = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  localparam logic [dos_pkg::CNT_W-1:0] CNT_LAST =
    dos_pkg::CNT_W'(dos_pkg::DIV_STEPS - 1);

  logic [2:0]                state;
  logic [2:0]                state_next;
  logic [dos_pkg::CNT_W-1:0] cnt;
  logic                      out_full;
  logic                      accept;
  logic                      out_free;

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid & s_tready;
  assign out_free = !out_full || m_tready;
  assign m_tvalid = out_full;

  // Commands
  always_comb begin
    cmd          = '0;
    cmd.load     = accept;
    cmd.div_step = (state == S_DIV);
    cmd.sign     = (state == S_SIGN);
    cmd.mul_p    = (state == S_MULP);
    cmd.mul_d    = (state == S_MULD);
    cmd.acc_add  = (state == S_ACC);
    cmd.finish   = (state == S_DONE) && out_free;
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (accept) begin
        state_next = S_DIV;
      end
      S_DIV: begin
        if (sts.zero_level || cnt == CNT_LAST) begin
          state_next = S_SIGN;
        end
      end
      S_SIGN: state_next = S_MULP;
      S_MULP: state_next = S_MULD;
      S_MULD: state_next = S_ACC;
      S_ACC:  state_next = S_DONE;
      S_DONE: if (out_free) begin
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // State, step count and output slot
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      cnt      <= '0;
      out_full <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_DIV) begin
        cnt <= cnt + 1'b1;
      end else begin
        cnt <= '0;
      end
      if (cmd.finish) begin
        out_full <= 1'b1;
      end else if (m_tready) begin
        out_full <= 1'b0;
      end
    end
  end

  `ASSERT_NEXT(a_accept_to_div, accept, state == S_DIV)
  `ASSERT_IMPL(a_finish_slot_free, cmd.finish, !out_full || m_tready)
  `ASSERT_NEXT(a_div_end, state == S_DIV && cnt == CNT_LAST, state == S_SIGN)
  `ASSERT_NEXT(a_finish_shows, cmd.finish, m_tvalid && state == S_IDLE)

endmodule
`default_nettype wire

[design/diff_over_sum_steering_pd_top.sv]
// Difference-over-sum steering PD controller.
// Input stream (s_*): one transfer carries the left and right outer inductor
// levels. Output stream (m_*): one transfer per input carries the clamped
// steering command, the normalized Q1.15 error, and in tuser a flag that is
// set when a zero level kept the previous error.
// Gains and the clamp limit are written over the APB port (0x0 prop_gain,
// 0x4 deriv_gain, 0x8 out_limit); write them only while the block is idle.
// Sequence: when both levels are nonzero the serial divider yields one
// quotient bit per step, then come sign, two passes through the shared
// multiplier, accumulate and clamp; when a level is zero the divider stops
// after its first step. One item is in flight at a time; a new input can be
// taken the cycle after the result is written.
// The result sits in an output register: while the receiver stalls the block
// still takes the next input and computes it, then waits to write it.
// Reset (rst, synchronous) clears the held error to zero, both gains to zero,
// the limit to 32767 and empties the output register.
`default_nettype none
module diff_over_sum_steering_pd_top (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // [10:0] left_level, [21:11] right_level, rest zero
  input  wire logic [dos_pkg::IN_TDATA_W-1:0]      s_tdata,
  input  wire logic                                s_tvalid,
  output logic                                     s_tready,
  // [15:0] steer_out, [31:16] norm_error
  output logic [dos_pkg::OUT_TDATA_W-1:0]          m_tdata,
  // [0] error_held
  output logic                                     m_tuser,
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [dos_pkg::ADDR_W-1:0]          paddr,
  input  wire logic [dos_pkg::APB_DW-1:0]          pwdata,
  output logic [dos_pkg::APB_DW-1:0]               prdata,
  output logic                                     pready
);

  localparam int LB = dos_pkg::LEVEL_BITS;

  dos_pkg::dos_cmd_t                   cmd;
  dos_pkg::dos_sts_t                   sts;
  logic signed [dos_pkg::GAIN_W-1:0]   prop_gain;
  logic signed [dos_pkg::GAIN_W-1:0]   deriv_gain;
  logic [dos_pkg::LIM_W-1:0]           out_limit;
  logic signed [dos_pkg::OUT_W-1:0]    steer_out;
  logic signed [dos_pkg::ERR_W-1:0]    norm_error;
  logic                                error_held;

  dos_regs u_regs (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .prop_gain  (prop_gain),
    .deriv_gain (deriv_gain),
    .out_limit  (out_limit)
  );

  dos_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  dos_dpath u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .left_level  (s_tdata[LB-1:0]),
    .right_level (s_tdata[2*LB-1:LB]),
    .prop_gain   (prop_gain),
    .deriv_gain  (deriv_gain),
    .out_limit   (out_limit),
    .steer_out   (steer_out),
    .norm_error  (norm_error),
    .error_held  (error_held)
  );

  // Pack the result
  assign m_tdata = {norm_error, steer_out};
  assign m_tuser = error_held;

endmodule
`default_nettype wire

[test/dos_steer_checker.sv]
`timescale 1ns / 100ps
module dos_steer_checker (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic [dos_pkg::IN_TDATA_W-1:0]  s_tdata,
  input  wire logic                            s_tvalid,
  input  wire logic                            s_tready,
  input  wire logic [dos_pkg::OUT_TDATA_W-1:0] m_tdata,
  input  wire logic                            m_tuser,
  input  wire logic                            m_tvalid,
  input  wire logic                            m_tready,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [dos_pkg::ADDR_W-1:0]      paddr,
  input  wire logic [dos_pkg::APB_DW-1:0]      pwdata,
  input  wire logic                            pready,
  output int                                   mismatches,
  output int                                   pending,
  output int                                   results_checked
);

  localparam int LB = dos_pkg::LEVEL_BITS;

  typedef struct packed {
    logic signed [dos_pkg::OUT_W-1:0] steer;
    logic signed [dos_pkg::ERR_W-1:0] err;
    logic                             held;
  } steer_result_t;

  // Shadow copy of the register file and the held error
  logic signed [dos_pkg::GAIN_W-1:0] prop_gain_r;
  logic signed [dos_pkg::GAIN_W-1:0] deriv_gain_r;
  logic [dos_pkg::LIM_W-1:0]         out_limit_r;
  logic signed [dos_pkg::ERR_W-1:0]  held_err;

  steer_result_t expected_steer_q[$];
  steer_result_t want;
  steer_result_t got;

  initial begin
    mismatches      = 0;
    pending         = 0;
    results_checked = 0;
  end

  // Normalized error, PD term, floor shift and symmetric clamp
  function automatic steer_result_t predict_steering(input logic [LB-1:0] left,
                                                     input logic [LB-1:0] right);
    longint sum, diff, mag, quo, e, prev, pd, lim;
    steer_result_t r;
    prev   = longint'(held_err);
    e      = prev;
    r.held = 1'b1;
    if (left != 0 && right != 0) begin
      sum  = longint'(left) + longint'(right);
      diff = longint'(left) - longint'(right);
      mag  = (diff < 0 ? -diff : diff) * 32768;
      quo  = mag / sum;
      if (quo > 32767)
        quo = 32767;
      e      = (diff < 0) ? -quo : quo;
      r.held = 1'b0;
    end
    pd  = longint'(prop_gain_r) * e + longint'(deriv_gain_r) * (e - prev);
    pd  = pd >>> dos_pkg::FRAC_BITS;
    lim = longint'(out_limit_r);
    if (pd > lim)
      pd = lim;
    if (pd < -lim)
      pd = -lim;
    r.steer = pd[dos_pkg::OUT_W-1:0];
    r.err   = e[dos_pkg::ERR_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      prop_gain_r  = '0;
      deriv_gain_r = '0;
      out_limit_r  = dos_pkg::LIMIT_RESET;
      held_err     = '0;
      expected_steer_q.delete();
    end else begin
      // Track register writes; unknown indexes are dropped
      if (psel && penable && pwrite && pready) begin
        case (paddr[dos_pkg::ADDR_W-1:2])
          dos_pkg::REG_PROP_GAIN:  prop_gain_r  = pwdata[dos_pkg::GAIN_W-1:0];
          dos_pkg::REG_DERIV_GAIN: deriv_gain_r = pwdata[dos_pkg::GAIN_W-1:0];
          dos_pkg::REG_OUT_LIMIT:  out_limit_r  = pwdata[dos_pkg::LIM_W-1:0];
          default: ;
        endcase
      end
      // Compare each result transfer against the oldest prediction
      if (m_tvalid && m_tready) begin
        got.steer = m_tdata[dos_pkg::OUT_W-1:0];
        got.err   = m_tdata[2*dos_pkg::OUT_W-1:dos_pkg::OUT_W];
        got.held  = m_tuser;
        if (expected_steer_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("[%0t] unexpected result: steer %0d err %0d held %0b", $time,
                     got.steer, got.err, got.held);
        end else begin
          want = expected_steer_q.pop_front();
          results_checked++;
          if (got.steer !== want.steer || got.err !== want.err || got.held !== want.held)
          begin
            mismatches++;
            if (mismatches <= 10)
              $display("[%0t] result %0d: exp steer %0d err %0d held %0b, got %0d %0d %0b",
                       $time, results_checked, want.steer, want.err, want.held,
                       got.steer, got.err, got.held);
          end
        end
      end
      // Predict on every input transfer and advance the held error
      if (s_tvalid && s_tready) begin
        want = predict_steering(s_tdata[LB-1:0], s_tdata[2*LB-1:LB]);
        held_err = want.err;
        expected_steer_q.push_back(want);
      end
    end
    pending = expected_steer_q.size();
  end

endmodule

[test/diff_over_sum_steering_pd_top_tb.sv]
`timescale 1ns / 100ps
module diff_over_sum_steering_pd_top_tb;

  localparam int CYCLE_LIMIT    = 600000;
  localparam int DRAIN_CYCLES   = 40;
  localparam int PHASE_ITEMS    = 194;
  localparam int LB             = dos_pkg::LEVEL_BITS;
  localparam int DW             = dos_pkg::APB_DW;
  localparam logic [1:0] REG_UNUSED = 2'd3;

  logic                               clk      = 1'b0;
  logic                               rst      = 1'b1;
  logic [dos_pkg::IN_TDATA_W-1:0]     s_tdata  = '0;
  logic                               s_tvalid = 1'b0;
  logic                               m_tready = 1'b0;
  logic                               psel     = 1'b0;
  logic                               penable  = 1'b0;
  logic                               pwrite   = 1'b0;
  logic [dos_pkg::ADDR_W-1:0]         paddr    = '0;
  logic [DW-1:0]                      pwdata   = '0;
  wire                                s_tready;
  wire [dos_pkg::OUT_TDATA_W-1:0]     m_tdata;
  wire                                m_tuser;
  wire                                m_tvalid;
  wire [DW-1:0]                       prdata;
  wire                                pready;

  int src_idle_pct  = 0;
  int snk_stall_pct = 0;
  int cycles        = 0;
  int items_sent    = 0;
  int settings_used = 0;
  int mismatches;
  int pending;
  int results_checked;

  diff_over_sum_steering_pd_top i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  dos_steer_checker i_checker (
    .clk             (clk),
    .rst             (rst),
    .s_tdata         (s_tdata),
    .s_tvalid        (s_tvalid),
    .s_tready        (s_tready),
    .m_tdata         (m_tdata),
    .m_tuser         (m_tuser),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .pready          (pready),
    .mismatches      (mismatches),
    .pending         (pending),
    .results_checked (results_checked)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Random receiver stalls
  always @(posedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= snk_stall_pct);
  end

  // Hard stop for a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Setup cycle, then access cycle; register lands when pready is high
  task automatic apb_write(input logic [1:0] idx, input logic [DW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(input int kp, input int kd, input int lim);
    apb_write(dos_pkg::REG_PROP_GAIN, DW'(kp));
    apb_write(dos_pkg::REG_DERIV_GAIN, DW'(kd));
    apb_write(dos_pkg::REG_OUT_LIMIT, DW'(lim));
    settings_used++;
  endtask

  // Hold valid until the transfer, with random gaps in front
  task automatic send_item(input int left, input int right);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(dos_pkg::IN_TDATA_W - 2*LB){1'b0}}, LB'(right), LB'(left)};
    do @(posedge clk); while (!s_tready);
    items_sent++;
  endtask

  // Drop valid and wait until every result is back and the block is quiet
  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic int pick_extreme();
    case ($urandom_range(0, 4))
      0:       return 1;
      1:       return 1023;
      2:       return 1024;
      3:       return 2;
      default: return (1 << LB) - 1;
    endcase
  endfunction

  // Mostly sensor-like levels, some zero levels, full-width noise and extremes
  task automatic send_random_item();
    int kind;
    int l, r;
    kind = $urandom_range(0, 99);
    if (kind < 60) begin
      l = int'($urandom_range(1, 1024));
      r = int'($urandom_range(1, 1024));
    end else if (kind < 72) begin
      l = ($urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(0, 1024));
      r = (l == 0 && $urandom_range(0, 1) != 0) ? int'($urandom_range(0, 1024)) : 0;
    end else if (kind < 90) begin
      l = int'($urandom_range(0, (1 << LB) - 1));
      r = int'($urandom_range(0, (1 << LB) - 1));
    end else begin
      l = pick_extreme();
      r = pick_extreme();
    end
    send_item(l, r);
  endtask

  function automatic int rand_gain();
    return int'($urandom_range(0, 65535)) - 32768;
  endfunction

  initial begin
    int ph;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset register values: zero gains, full limit
    send_item(700, 300);
    send_item(0, 9);
    settle();

    // Extreme gains, full error swings, zero levels
    configure(32767, -32768, 32767);
    send_item(2047, 1);
    send_item(1, 2047);
    send_item(0, 0);
    send_item(2047, 2047);
    send_item(1, 1);
    send_item(1024, 0);
    send_item(1, 1024);
    send_item(1024, 1);
    send_item(0, 1024);
    send_item(1024, 1024);
    send_item(1, 2);
    send_item(2, 1);
    settle();

    // Zero limit forces a zero command; write to an unknown index is dropped
    configure(-32768, 32767, 0);
    apb_write(REG_UNUSED, $urandom);
    send_item(1, 2047);
    send_item(2047, 1);
    send_item(5, 0);
    settle();

    configure(-32768, -32768, 1);
    send_item(1, 2047);
    send_item(2047, 1);
    settle();

    // Random phases across settings and handshake pressure
    for (ph = 0; ph < 8; ph++) begin
      case (ph)
        0:       configure(32767, 32767, 32767);
        1:       configure(-32768, -32768, 32767);
        3:       configure(4096, 16384, 2000);
        5:       configure(-32768, 32767, 1);
        6:       configure(rand_gain(), rand_gain(), 32767);
        default: configure(rand_gain(), rand_gain(), int'($urandom_range(0, 32767)));
      endcase
      case (ph % 4)
        0:       begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1:       begin src_idle_pct = 69; snk_stall_pct = 0;  end
        2:       begin src_idle_pct = 0;  snk_stall_pct = 69; end
        default: begin src_idle_pct = 31; snk_stall_pct = 31; end
      endcase
      repeat (PHASE_ITEMS) send_random_item();
      settle();
    end

    $display("Covered %0d input transfers, %0d results checked, %0d register settings,",
             items_sent, results_checked, settings_used);
    $display("with zero levels, extreme levels and gains, zero limit and four stall mixes.");
    if (mismatches == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
